// ===== sv/ntkt_pkg.sv =====
// ----------------------------------------------------------------------------
// ntkt_pkg
// Shared types and constants for the nearest timestamp key table.
// ----------------------------------------------------------------------------
`default_nettype none

package ntkt_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int TIME_W          = 48;
    localparam int KEY_W           = 64;
    localparam int GAP_W           = 32;
    localparam int KIND_W          = 2;
    localparam int STATUS_W        = 2;

    localparam logic [GAP_W-1:0] GAP_RESET = 32'd1000000;

    localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXACT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEAREST = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_FAR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef logic [TIME_W-1:0] tstamp_t;
    typedef logic [KEY_W-1:0]  key_t;

    // Commands broadcast to every cell
    typedef struct packed {
        logic cmp_en;   // latch compare flags against the query time
        logic shift;    // open a slot at the insert point, shift the tail up
        logic eq_wr;    // overwrite key in the cell holding an equal time
    } cell_ctl_t;

    // Per-cell position flags
    typedef struct packed {
        logic eq;       // cell time equals query
        logic lo;       // last cell below query
        logic hi;       // first occupied cell not below query
    } cell_tap_t;

endpackage

`default_nettype wire

// ===== sv/ntkt_cell.sv =====
// ----------------------------------------------------------------------------
// ntkt_cell
// One slot of the sorted chain: holds a timestamp and key, compares them
// against the query and on insert takes its lower neighbor's entry, or the new entry at the insert point.
// ----------------------------------------------------------------------------
`default_nettype none

module ntkt_cell
    import ntkt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire logic      occ,
    input  wire tstamp_t   query_time,
    input  wire key_t      new_key,
    input  wire logic      prev_lt,
    input  wire logic      next_lt,
    input  wire tstamp_t   prev_time,
    input  wire key_t      prev_key,
    output logic           lt,
    output tstamp_t        cell_time,
    output key_t           cell_key,
    output cell_tap_t      tap
);

    logic    lt_reg;
    logic    eq_reg;
    tstamp_t time_reg;
    key_t    key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctl.cmp_en)
        begin
            lt_reg <= occ && (time_reg < query_time);
            eq_reg <= occ && (time_reg == query_time);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift && !lt_reg)
        begin
            time_reg <= prev_lt ? query_time : prev_time;
            key_reg  <= prev_lt ? new_key : prev_key;
        end
        else if (ctl.eq_wr && eq_reg)
        begin
            key_reg <= new_key;
        end
    end

    assign lt        = lt_reg;
    assign cell_time = time_reg;
    assign cell_key  = key_reg;
    assign tap.eq    = eq_reg;
    assign tap.lo    = lt_reg && !next_lt;
    assign tap.hi    = occ && !lt_reg && prev_lt;

endmodule

`default_nettype wire

// ===== sv/nearest_timestamp_key_table.sv =====
// ----------------------------------------------------------------------------
// nearest_timestamp_key_table
// Time-sorted table of (timestamp, key) entries with insert, exact lookup
// and nearest lookup.
// ----------------------------------------------------------------------------
// Entries live in a chain of TABLE_DEPTH cells kept in ascending time order;
// an insert shifts every cell of the tail of the chain up by one cell at once.
// Each item passes through the states IDLE, which accepts it, CMP, in which
// every cell compares against the query time, SEL, which reduces the cell
// flags to the neighbors around the query (and applies an insert), DIST,
// which picks the nearer neighbor, and FIN, which checks the gap limit and
// loads the output register. A new item is taken once the previous one
// leaves the compute path, while its result may still wait in the output
// register; a finished result that finds the output register full and
// stalled keeps the input stalled until it moves. The gap limit (gap_reg)
// resets to one second; cfg_ready is always high.
`default_nettype none

module nearest_timestamp_key_table
    import ntkt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [GAP_W-1:0]    cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [KIND_W-1:0]   kind,
    input  wire logic [TIME_W-1:0]   time_us,
    input  wire logic [KEY_W-1:0]    entry_key,
    input  wire logic                enforce_limit,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [KEY_W-1:0]         found_key,
    output logic [STATUS_W-1:0]      status,
    output logic [TIME_W-1:0]        matched_time_us,
    output logic                     beyond_range,
    output logic                     over_limit
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_DIST = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [GAP_W-1:0]  gap_reg;

    logic [KIND_W-1:0] kind_reg;
    tstamp_t           q_time_reg;
    key_t              q_key_reg;
    logic              enforce_reg;

    cell_ctl_t         ctl;
    logic [TABLE_DEPTH-1:0] lt_vec, eq_vec, lo_vec, hi_vec;
    tstamp_t [TABLE_DEPTH-1:0] time_arr;
    key_t    [TABLE_DEPTH-1:0] key_arr;
    key_t    [TABLE_DEPTH-1:0] eqk_arr, lok_arr, hik_arr;
    tstamp_t [TABLE_DEPTH-1:0] lot_arr, hit_arr;

    key_t    eq_key_red, lo_key_red, hi_key_red;
    tstamp_t lo_time_red, hi_time_red;
    logic [TABLE_DEPTH-1:0] col;

    logic    any_eq_reg, any_lo_reg, any_hi_reg, full_reg;
    key_t    eq_key_reg, lo_key_reg, hi_key_reg;
    tstamp_t lo_time_reg, hi_time_reg;

    tstamp_t below, above;
    logic    sel_hi;
    logic    empty_reg, beyond_reg;
    tstamp_t m_time_reg, dist_reg;
    key_t    m_key_reg;

    logic    is_insert, do_insert, out_load, over;

    key_t                res_key;
    logic [STATUS_W-1:0] res_status;
    tstamp_t             res_time;
    logic                res_beyond, res_over;

    key_t                found_key_reg;
    logic [STATUS_W-1:0] status_reg;
    tstamp_t             matched_time_reg;
    logic                beyond_out_reg, over_out_reg, out_valid_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);

    assign is_insert = (kind_reg == KIND_INSERT);
    assign do_insert = (state_reg == S_SEL) && is_insert && !(|eq_vec)
                       && (count_reg != CNT_FULL);

    assign ctl.cmp_en = (state_reg == S_CMP);
    assign ctl.shift  = do_insert;
    assign ctl.eq_wr  = (state_reg == S_SEL) && is_insert;

    // ---- cell chain ----
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic    p_lt, n_lt;
        tstamp_t p_time;
        key_t    p_key;
        cell_tap_t tap;

        if (i == 0)
        begin : g_first
            assign p_lt   = 1'b1;
            assign p_time = q_time_reg;
            assign p_key  = q_key_reg;
        end
        else
        begin : g_rest
            assign p_lt   = lt_vec[i-1];
            assign p_time = time_arr[i-1];
            assign p_key  = key_arr[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign n_lt = 1'b0;
        end
        else
        begin : g_mid
            assign n_lt = lt_vec[i+1];
        end

        ntkt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .occ        (CNT_W'(i) < count_reg),
            .query_time (q_time_reg),
            .new_key    (q_key_reg),
            .prev_lt    (p_lt),
            .next_lt    (n_lt),
            .prev_time  (p_time),
            .prev_key   (p_key),
            .lt         (lt_vec[i]),
            .cell_time  (time_arr[i]),
            .cell_key   (key_arr[i]),
            .tap        (tap)
        );

        assign eq_vec[i]  = tap.eq;
        assign lo_vec[i]  = tap.lo;
        assign hi_vec[i]  = tap.hi;
        assign eqk_arr[i] = tap.eq ? key_arr[i]  : '0;
        assign lok_arr[i] = tap.lo ? key_arr[i]  : '0;
        assign hik_arr[i] = tap.hi ? key_arr[i]  : '0;
        assign lot_arr[i] = tap.lo ? time_arr[i] : '0;
        assign hit_arr[i] = tap.hi ? time_arr[i] : '0;
    end

    // one-hot OR reduction, bit column by bit column
    always_comb
    begin
        col = '0;
        for (int b = 0; b < KEY_W; b++)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++) col[i] = eqk_arr[i][b];
            eq_key_red[b] = |col;
            for (int i = 0; i < TABLE_DEPTH; i++) col[i] = lok_arr[i][b];
            lo_key_red[b] = |col;
            for (int i = 0; i < TABLE_DEPTH; i++) col[i] = hik_arr[i][b];
            hi_key_red[b] = |col;
        end
        for (int b = 0; b < TIME_W; b++)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++) col[i] = lot_arr[i][b];
            lo_time_red[b] = |col;
            for (int i = 0; i < TABLE_DEPTH; i++) col[i] = hit_arr[i][b];
            hi_time_red[b] = |col;
        end
    end

    // ---- control ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_CMP;
            S_CMP:   state_next = S_SEL;
            S_SEL:   state_next = S_DIST;
            S_DIST:  state_next = S_FIN;
            S_FIN:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            gap_reg       <= GAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_insert) count_reg <= count_reg + CNT_W'(1);
            if (cfg_valid) gap_reg <= cfg_data;
            if (out_load) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;
        end
    end

    // ---- datapath ----
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            kind_reg    <= kind;
            q_time_reg  <= time_us;
            q_key_reg   <= entry_key;
            enforce_reg <= enforce_limit;
        end
        if (state_reg == S_SEL)
        begin
            any_eq_reg  <= |eq_vec;
            any_lo_reg  <= |lo_vec;
            any_hi_reg  <= |hi_vec;
            full_reg    <= (count_reg == CNT_FULL);
            eq_key_reg  <= eq_key_red;
            lo_key_reg  <= lo_key_red;
            hi_key_reg  <= hi_key_red;
            lo_time_reg <= lo_time_red;
            hi_time_reg <= hi_time_red;
        end
        if (state_reg == S_DIST)
        begin
            empty_reg  <= !any_lo_reg && !any_hi_reg;
            beyond_reg <= any_hi_reg ? (!any_lo_reg && (hi_time_reg != q_time_reg))
                                     : 1'b1;
            m_time_reg <= sel_hi ? hi_time_reg : lo_time_reg;
            m_key_reg  <= sel_hi ? hi_key_reg  : lo_key_reg;
            dist_reg   <= sel_hi ? above : below;
        end
        if (out_load)
        begin
            found_key_reg    <= res_key;
            status_reg       <= res_status;
            matched_time_reg <= res_time;
            beyond_out_reg   <= res_beyond;
            over_out_reg     <= res_over;
        end
    end

    assign below  = q_time_reg - lo_time_reg;
    assign above  = hi_time_reg - q_time_reg;
    assign sel_hi = any_hi_reg && !(any_lo_reg && (below < above));

    assign over = (dist_reg > TIME_W'(gap_reg));

    always_comb
    begin
        res_key    = '0;
        res_status = ST_NONE;
        res_time   = '0;
        res_beyond = 1'b0;
        res_over   = 1'b0;
        case (kind_reg)
            KIND_INSERT:
            begin
                if (any_eq_reg || !full_reg)
                begin
                    res_key    = q_key_reg;
                    res_status = ST_OK;
                    res_time   = q_time_reg;
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            KIND_EXACT:
            begin
                if (any_eq_reg)
                begin
                    res_key    = eq_key_reg;
                    res_status = ST_OK;
                    res_time   = q_time_reg;
                end
            end
            KIND_NEAREST:
            begin
                if (!empty_reg)
                begin
                    res_time   = m_time_reg;
                    res_beyond = beyond_reg;
                    res_over   = over;
                    if (over && enforce_reg)
                    begin
                        res_status = ST_TOO_FAR;
                    end
                    else
                    begin
                        res_status = ST_OK;
                        res_key    = m_key_reg;
                    end
                end
            end
            default:
            begin
                res_status = ST_NONE;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign found_key       = found_key_reg;
    assign status          = status_reg;
    assign matched_time_us = matched_time_reg;
    assign beyond_range    = beyond_out_reg;
    assign over_limit      = over_out_reg;

    // ---- assertions ----
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("entry count moved by other than one");

    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(eq_vec) && $onehot0(lo_vec) && $onehot0(hi_vec))
        else $error("chain order broken: multiple boundary cells");

    a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_CMP))
        else $error("accepted item did not start compare");

endmodule

`default_nettype wire
